// ----- rtl/fcp_pkg.sv -----
// shared constants for the fan curve pwm controller
`default_nettype none

package fcp_pkg;

  localparam int TEMP_BITS_DEF = 18;
  localparam int PWM_BITS_DEF  = 8;

  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_TEMP = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_PWM  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_TEMP  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_PWM   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_TEMP = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_PWM  = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RISE_BAND = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_FALL_BAND = 3'd7;

  localparam int BASE_TEMP_RST = 40000;
  localparam int BASE_PWM_RST  = 80;
  localparam int LOW_TEMP_RST  = 45000;
  localparam int LOW_PWM_RST   = 80;
  localparam int HIGH_TEMP_RST = 70000;
  localparam int HIGH_PWM_RST  = 255;
  localparam int RISE_BAND_RST = 2000;
  localparam int FALL_BAND_RST = 2000;

endpackage

`default_nettype wire

// ----- rtl/fcp_in_if.sv -----
// temperature request channel
`default_nettype none

interface fcp_in_if #(
  parameter int TEMP_BITS = fcp_pkg::TEMP_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TEMP_BITS-1:0] sample_temp;

  modport source (output valid, output sample_temp, input ready);
  modport sink   (input valid, input sample_temp, output ready);
endinterface

`default_nettype wire

// ----- rtl/fcp_out_if.sv -----
// pwm result channel
`default_nettype none

interface fcp_out_if #(
  parameter int PWM_BITS = fcp_pkg::PWM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [PWM_BITS-1:0] pwm_out;
  logic                spin_start;

  modport source (output valid, output pwm_out, output spin_start, input ready);
  modport sink   (input valid, input pwm_out, input spin_start, output ready);
endinterface

`default_nettype wire

// ----- rtl/fcp_cfg_if.sv -----
// configuration write channel
`default_nettype none

interface fcp_cfg_if #(
  parameter int DATA_BITS = fcp_pkg::TEMP_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [fcp_pkg::CFG_IDX_BITS-1:0] index;
  logic [DATA_BITS-1:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fan_curve_pwm_controller.sv -----
// interpolated samples pass through check, multiply, divider start, divider wait and spin-up adjust before the result
// samples on a flat part of the curve go from check straight to the spin-up adjust and the result
// samples inside the hysteresis band return to idle from the check state, no result
// throughput: one sample at a time, set by the bit-serial divider (one quotient bit a cycle)
// reset: rst_n synchronous active low, loads the curve defaults, clears the sequencer,
// stored temperature and kick flag, and sets the stored pwm to all ones
`default_nettype none

module fan_curve_pwm_controller #(
  parameter int TEMP_BITS = fcp_pkg::TEMP_BITS_DEF,
  parameter int PWM_BITS  = fcp_pkg::PWM_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  fcp_in_if.sink    in_chan,
  fcp_out_if.source out_chan,
  fcp_cfg_if.sink   cfg_chan
);

  // product of pwm span and temperature offset, also the divider width
  localparam int NUM_BITS = TEMP_BITS + PWM_BITS;

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIVGO = 3'd3;
  localparam logic [2:0] S_DIVWT = 3'd4;
  localparam logic [2:0] S_SPIN  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [TEMP_BITS-1:0] base_temp, low_temp, high_temp, rise_band, fall_band;
  logic [PWM_BITS-1:0]  base_pwm, low_pwm, high_pwm;

  logic [2:0]           state_r, state_nxt;
  logic [TEMP_BITS-1:0] t_r, dt_r, span_r, prev_temp_r;
  logic [PWM_BITS-1:0]  diff_r, pwm_r, prev_pwm_r, out_pwm_r;
  logic                 desc_r, kick_r, out_spin_r;
  logic [NUM_BITS-1:0]  prod_r;

  // band and curve decisions on the held sample
  logic [TEMP_BITS:0]   rise_lim, fall_sum;
  logic                 want_upd, below_base, below_low, below_high, desc;

  // divider hookup
  logic                 div_start, div_done;
  logic [NUM_BITS-1:0]  div_num, div_quo;
  logic [PWM_BITS-1:0]  q, interp_pwm;

  // spin-up adjust
  logic                 spin;
  logic [PWM_BITS-1:0]  spin_pwm;

  fcp_cfg_regs #(
    .TEMP_BITS (TEMP_BITS),
    .PWM_BITS  (PWM_BITS)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_chan),
    .base_temp (base_temp),
    .base_pwm  (base_pwm),
    .low_temp  (low_temp),
    .low_pwm   (low_pwm),
    .high_temp (high_temp),
    .high_pwm  (high_pwm),
    .rise_band (rise_band),
    .fall_band (fall_band)
  );

  // band sums carry one extra bit so a wide band never wraps
  assign rise_lim = {1'b0, prev_temp_r} + {1'b0, rise_band};
  assign fall_sum = {1'b0, t_r} + {1'b0, fall_band};
  assign want_upd = ({1'b0, t_r} > rise_lim) || (fall_sum < {1'b0, prev_temp_r}) ||
                    kick_r || (prev_temp_r == '0) || (prev_pwm_r == '1);

  assign below_base = t_r < base_temp;
  assign below_low  = t_r < low_temp;
  assign below_high = t_r < high_temp;
  assign desc       = high_pwm < low_pwm;

  // a falling segment rounds the quotient up so the result is the floor of the line
  assign div_start = (state_r == S_DIVGO);
  assign div_num   = desc_r ? prod_r + NUM_BITS'(span_r - TEMP_BITS'(1)) : prod_r;

  fcp_divider #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (TEMP_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (span_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // quotient never exceeds the pwm span, so the low bits hold it
  assign q          = div_quo[PWM_BITS-1:0];
  assign interp_pwm = desc_r ? low_pwm - q : low_pwm + q;

  // fan leaving the off state is raised to at least the start pwm
  assign spin     = (prev_pwm_r == '0) && (pwm_r != '0);
  assign spin_pwm = (spin && (pwm_r < base_pwm)) ? base_pwm : pwm_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_chan.valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (!want_upd) state_nxt = S_IDLE;
        else if (below_base || below_low || !below_high) state_nxt = S_SPIN;
        else state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVWT;
      S_DIVWT: if (div_done) state_nxt = S_SPIN;
      S_SPIN:  state_nxt = S_OUT;
      S_OUT:   if (out_chan.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_temp_r <= '0;
      prev_pwm_r  <= '1;
      kick_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // stored state moves only when a result is committed
      if (state_r == S_SPIN) begin
        prev_temp_r <= t_r;
        prev_pwm_r  <= spin_pwm;
        kick_r      <= spin;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_chan.valid) t_r <= in_chan.sample_temp;
    if (state_r == S_CHECK) begin
      dt_r   <= t_r - low_temp;
      span_r <= high_temp - low_temp;
      desc_r <= desc;
      diff_r <= desc ? low_pwm - high_pwm : high_pwm - low_pwm;
      if (below_base) pwm_r <= '0;
      else if (below_low) pwm_r <= low_pwm;
      else pwm_r <= high_pwm;
    end
    if (state_r == S_MUL) prod_r <= NUM_BITS'(diff_r) * NUM_BITS'(dt_r);
    if (state_r == S_DIVWT && div_done) pwm_r <= interp_pwm;
    if (state_r == S_SPIN) begin
      out_pwm_r  <= spin_pwm;
      out_spin_r <= spin;
    end
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = (state_r == S_OUT);
  assign out_chan.pwm_out    = out_pwm_r;
  assign out_chan.spin_start = out_spin_r;

endmodule

`default_nettype wire

// ----- rtl/fcp_cfg_regs.sv -----
// fan curve configuration registers
`default_nettype none

module fcp_cfg_regs #(
  parameter int TEMP_BITS = fcp_pkg::TEMP_BITS_DEF,
  parameter int PWM_BITS  = fcp_pkg::PWM_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  fcp_cfg_if.sink            cfg,
  output logic [TEMP_BITS-1:0] base_temp,
  output logic [PWM_BITS-1:0]  base_pwm,
  output logic [TEMP_BITS-1:0] low_temp,
  output logic [PWM_BITS-1:0]  low_pwm,
  output logic [TEMP_BITS-1:0] high_temp,
  output logic [PWM_BITS-1:0]  high_pwm,
  output logic [TEMP_BITS-1:0] rise_band,
  output logic [TEMP_BITS-1:0] fall_band
);

  logic [TEMP_BITS-1:0] base_temp_r, low_temp_r, high_temp_r, rise_band_r, fall_band_r;
  logic [PWM_BITS-1:0]  base_pwm_r, low_pwm_r, high_pwm_r;
  logic [TEMP_BITS-1:0] wr_temp;
  logic [PWM_BITS-1:0]  wr_pwm;

  assign cfg.ready = 1'b1;
  assign wr_temp   = cfg.data[TEMP_BITS-1:0];
  assign wr_pwm    = cfg.data[PWM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_temp_r <= TEMP_BITS'(fcp_pkg::BASE_TEMP_RST);
      base_pwm_r  <= PWM_BITS'(fcp_pkg::BASE_PWM_RST);
      low_temp_r  <= TEMP_BITS'(fcp_pkg::LOW_TEMP_RST);
      low_pwm_r   <= PWM_BITS'(fcp_pkg::LOW_PWM_RST);
      high_temp_r <= TEMP_BITS'(fcp_pkg::HIGH_TEMP_RST);
      high_pwm_r  <= PWM_BITS'(fcp_pkg::HIGH_PWM_RST);
      rise_band_r <= TEMP_BITS'(fcp_pkg::RISE_BAND_RST);
      fall_band_r <= TEMP_BITS'(fcp_pkg::FALL_BAND_RST);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fcp_pkg::REG_BASE_TEMP: base_temp_r <= wr_temp;
        fcp_pkg::REG_BASE_PWM:  base_pwm_r  <= wr_pwm;
        fcp_pkg::REG_LOW_TEMP:  low_temp_r  <= wr_temp;
        fcp_pkg::REG_LOW_PWM:   low_pwm_r   <= wr_pwm;
        fcp_pkg::REG_HIGH_TEMP: high_temp_r <= wr_temp;
        fcp_pkg::REG_HIGH_PWM:  high_pwm_r  <= wr_pwm;
        fcp_pkg::REG_RISE_BAND: rise_band_r <= wr_temp;
        fcp_pkg::REG_FALL_BAND: fall_band_r <= wr_temp;
        default: ;
      endcase
    end
  end

  assign base_temp = base_temp_r;
  assign base_pwm  = base_pwm_r;
  assign low_temp  = low_temp_r;
  assign low_pwm   = low_pwm_r;
  assign high_temp = high_temp_r;
  assign high_pwm  = high_pwm_r;
  assign rise_band = rise_band_r;
  assign fall_band = fall_band_r;

endmodule

`default_nettype wire

// ----- rtl/fcp_divider.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module fcp_divider #(
  parameter int NUM_BITS = fcp_pkg::TEMP_BITS_DEF + fcp_pkg::PWM_BITS_DEF,
  parameter int DEN_BITS = fcp_pkg::TEMP_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic                     done,
  output logic [NUM_BITS-1:0]      quo
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] num_r, quo_r;
  logic [DEN_BITS-1:0] den_r, rem_r, rem_nxt;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r, done_r;
  logic [DEN_BITS:0]   trial, trial_sub;
  logic                fits;

  // shift in the next numerator bit and try a subtract
  assign trial     = {rem_r, num_r[NUM_BITS-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign fits      = trial >= {1'b0, den_r};
  assign rem_nxt   = fits ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(NUM_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[NUM_BITS-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire
